[src/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the play/silence detector
// Phase encoding, register index map, register widths and reset values.
// ----------------------------------------------------------------------------
package psd_pkg;

	// Detector phase
	typedef enum logic [1:0] {
		PH_LISTEN = 2'd0,
		PH_PLAY   = 2'd1,
		PH_STOP   = 2'd2
	} phase_t;

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_NOISE_THRESHOLD   = 3'd0,
		REG_SILENCE_THRESHOLD = 3'd1,
		REG_START_COUNT       = 3'd2,
		REG_ANOMALY_LIMIT     = 3'd3,
		REG_STOP_COUNT        = 3'd4
	} reg_idx_t;

	// Field widths
	localparam int LEVEL_W = 15;
	localparam int MAG_W   = 16;
	localparam int THR_W   = 15;
	localparam int COUNT_W = 16;
	localparam int ANOM_W  = 8;
	localparam int DATA_W  = 16;

	// Register reset values
	localparam logic [THR_W-1:0]   NOISE_THRESHOLD_RST   = 15'd1000;
	localparam logic [THR_W-1:0]   SILENCE_THRESHOLD_RST = 15'd500;
	localparam logic [COUNT_W-1:0] START_COUNT_RST       = 16'd100;
	localparam logic [ANOM_W-1:0]  ANOMALY_LIMIT_RST     = 8'd10;
	localparam logic [COUNT_W-1:0] STOP_COUNT_RST        = 16'd44100;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

endpackage

[src/psd_mag.sv]
// ----------------------------------------------------------------------------
// psd_mag: sample magnitude in Q0.15 steps
// Absolute value of a signed sample, aligned to 15 fraction bits (truncating
// right shift or zero-filled left shift), plus the level saturated at 32767.
// ----------------------------------------------------------------------------
module psd_mag
	import psd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic        [MAG_W-1:0]       mag,
	output logic        [LEVEL_W-1:0]     level
);

	localparam int SHR = (SAMPLE_BITS >= MAG_W) ? SAMPLE_BITS - MAG_W : 0;
	localparam int SHL = (SAMPLE_BITS < MAG_W) ? MAG_W - SAMPLE_BITS : 0;

	logic [SAMPLE_BITS-1:0] mag_raw;

	// two's complement negate; the most negative code maps onto itself,
	// which is exactly its magnitude read as unsigned
	assign mag_raw = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

	// align to 15 fraction bits
	generate
		if (SAMPLE_BITS >= MAG_W) begin : g_shr
			assign mag = MAG_W'(mag_raw >> SHR);
		end else begin : g_shl
			assign mag = {mag_raw, {SHL{1'b0}}};
		end
	endgenerate

	// only the display level saturates
	assign level = mag[MAG_W-1] ? LEVEL_MAX : mag[LEVEL_W-1:0];

endmodule

[src/play_silence_detector.sv]
// ----------------------------------------------------------------------------
// play_silence_detector: take detector for a live performance
// Reports sample level and tracks listening, playing and stopped phases.
// ----------------------------------------------------------------------------
// One sample per clock is accepted while in_stall is low, and one result beat
// is returned per sample, in order. A sample's result is evaluated in the
// input register, where the magnitude, the threshold compares and the count
// update are computed, then it sits in the result register until taken. The
// output register lets a new sample enter while a result is still waiting;
// in_stall only rises when both registers are full and the output is stalled.
// Registers are written through wr_en/wr_index/wr_data; the user must write
// them only while the block is idle, which the block itself does not enforce;
// unknown indexes are ignored. After the stop trigger the block keeps
// reporting level but stays stopped until reset.
module play_silence_detector
	import psd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration
	input  logic                          wr_en,
	input  logic [REG_IDX_W-1:0]          wr_index,
	input  logic [DATA_W-1:0]             wr_data,

	// sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,

	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [LEVEL_W-1:0]            level,
	output logic                          playing,
	output logic                          stop_trigger,
	output logic                          stopped
);

	// configuration registers
	logic [THR_W-1:0]   noise_threshold_q;
	logic [THR_W-1:0]   silence_threshold_q;
	logic [COUNT_W-1:0] start_count_q;
	logic [ANOM_W-1:0]  anomaly_limit_q;
	logic [COUNT_W-1:0] stop_count_q;

	// pipeline
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          advance;
	logic                          in_accept;

	// detector state
	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] run_count_q, run_count_d;
	logic [ANOM_W-1:0]  anomaly_count_q, anomaly_count_d;
	logic               trig_d;

	// magnitude
	logic [MAG_W-1:0]   mag;
	logic [LEVEL_W-1:0] level_d;

	// result register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic               playing_q;
	logic               stop_trigger_q;
	logic               stopped_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_threshold_q   <= NOISE_THRESHOLD_RST;
			silence_threshold_q <= SILENCE_THRESHOLD_RST;
			start_count_q       <= START_COUNT_RST;
			anomaly_limit_q     <= ANOMALY_LIMIT_RST;
			stop_count_q        <= STOP_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_NOISE_THRESHOLD:   noise_threshold_q   <= wr_data[THR_W-1:0];
				REG_SILENCE_THRESHOLD: silence_threshold_q <= wr_data[THR_W-1:0];
				REG_START_COUNT:       start_count_q       <= wr_data[COUNT_W-1:0];
				REG_ANOMALY_LIMIT:     anomaly_limit_q     <= wr_data[ANOM_W-1:0];
				REG_STOP_COUNT:        stop_count_q        <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves on when the result register is free or draining
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= sample;
		end
	end

	psd_mag #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mag (
		.sample (sample_s1),
		.mag    (mag),
		.level  (level_d)
	);

	// state register, updated as the beat leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_LISTEN;
			run_count_q     <= '0;
			anomaly_count_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q         <= phase_d;
			run_count_q     <= run_count_d;
			anomaly_count_q <= anomaly_count_d;
		end
	end

	// next state
	always_comb begin
		logic [COUNT_W-1:0] run_inc;
		logic [ANOM_W-1:0]  anom_inc;

		run_inc  = (run_count_q == '1) ? run_count_q : run_count_q + 1'b1;
		anom_inc = (anomaly_count_q == '1) ? anomaly_count_q : anomaly_count_q + 1'b1;

		phase_d         = phase_q;
		run_count_d     = run_count_q;
		anomaly_count_d = anomaly_count_q;
		trig_d          = 1'b0;

		case (phase_q)
			PH_LISTEN: begin
				// loud samples accumulate; quiet samples never clear the count
				if (mag > MAG_W'(noise_threshold_q)) begin
					run_count_d = run_inc;
					if (run_inc > start_count_q) begin
						run_count_d = '0;
						phase_d     = PH_PLAY;
					end
				end
			end
			PH_PLAY: begin
				if (mag < MAG_W'(silence_threshold_q)) begin
					run_count_d     = run_inc;
					anomaly_count_d = '0;
				end else if (anomaly_count_q <= anomaly_limit_q) begin
					// short loud run still counts toward silence
					run_count_d     = run_inc;
					anomaly_count_d = anom_inc;
				end else begin
					// long loud run: real playing, restart silence count
					run_count_d     = '0;
					anomaly_count_d = '0;
				end
				if (run_count_d >= stop_count_q) begin
					trig_d  = 1'b1;
					phase_d = PH_STOP;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			level_q        <= level_d;
			playing_q      <= (phase_d == PH_PLAY);
			stop_trigger_q <= trig_d;
			stopped_q      <= phase_d[1];
		end
	end

	assign out_valid    = out_valid_q;
	assign level        = level_q;
	assign playing      = playing_q;
	assign stop_trigger = stop_trigger_q;
	assign stopped      = stopped_q;

	// checks
	a_trig_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_trigger |-> stopped && !playing)
		else $error("stop trigger without stopped phase");

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(playing && stopped))
		else $error("playing and stopped together");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOP |=> phase_q == PH_STOP)
		else $error("left stopped phase");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

	a_trig_once: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && trig_d |-> phase_q == PH_PLAY)
		else $error("stop trigger outside playing phase");

endmodule
